[hdl/sri_pkg.sv]
// ----------------------------------------------------------------------------
// sri_pkg: shared types and constants
// Payload structs, lane-to-merge struct and widths for the segment
// versus quadrilateral intersection block.
// ----------------------------------------------------------------------------
package sri_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned CrossW    = ProdW + 1;
  localparam int unsigned MagW      = CrossW - 1;
  localparam int unsigned FracW     = FracBits + 1;
  localparam int unsigned NumLanes  = 4;
  // Pipeline depth of one lane: differences, products, crosses, normalize,
  // one stage per quotient bit.
  localparam int unsigned DivSteps  = FracBits + 1;
  localparam int unsigned LaneDepth = 4 + DivSteps;

  typedef struct packed {
    logic signed [CoordW-1:0] seg_start_x;
    logic signed [CoordW-1:0] seg_start_y;
    logic signed [CoordW-1:0] seg_end_x;
    logic signed [CoordW-1:0] seg_end_y;
    logic signed [CoordW-1:0] corner_a_x;
    logic signed [CoordW-1:0] corner_a_y;
    logic signed [CoordW-1:0] corner_b_x;
    logic signed [CoordW-1:0] corner_b_y;
    logic signed [CoordW-1:0] corner_c_x;
    logic signed [CoordW-1:0] corner_c_y;
    logic signed [CoordW-1:0] corner_d_x;
    logic signed [CoordW-1:0] corner_d_y;
  } sri_in_t;

  typedef struct packed {
    logic             hit;
    logic [FracW-1:0] hit_fraction;
  } sri_out_t;

  typedef struct packed {
    logic             hit;
    logic [FracW-1:0] frac;
  } lane_res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] p0x;
    logic signed [CoordW-1:0] p0y;
    logic signed [CoordW-1:0] p1x;
    logic signed [CoordW-1:0] p1y;
    logic signed [CoordW-1:0] e0x;
    logic signed [CoordW-1:0] e0y;
    logic signed [CoordW-1:0] e1x;
    logic signed [CoordW-1:0] e1y;
  } edge_in_t;

endpackage

[hdl/sri_lane.sv]
// ----------------------------------------------------------------------------
// sri_lane: one edge intersection lane
// Pipelined cross products, exact range test and a restoring divider
// with one quotient bit per stage. Advances whenever en_i is high.
// ----------------------------------------------------------------------------
module sri_lane import sri_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  edge_in_t  edge_i,
  output lane_res_t res_o
);

  // Stage 1: differences.
  logic signed [DiffW-1:0] s1x_q, s1y_q, s2x_q, s2y_q, dx_q, dy_q;
  // Stage 2: products.
  logic signed [ProdW-1:0] p_a_q, p_b_q, p_c_q, p_d_q, p_e_q, p_f_q;
  // Stage 3: cross products.
  logic signed [CrossW-1:0] den_q, sn_q, tn_q;
  // Stage 4: normalized magnitudes and range check.
  logic [MagW-1:0] dmag_q, tmag_q;
  logic            ok_q;
  // Divider stages.
  logic [MagW:0]     rem_q [DivSteps];
  logic [MagW-1:0]   dv_q  [DivSteps];
  logic [FracW-1:0]  quo_q [DivSteps];
  logic              hv_q  [DivSteps];

  logic signed [CrossW-1:0] den_n, sn_n, tn_n;
  logic                     den_neg;

  always_comb begin
    den_neg = den_q[CrossW-1];
    den_n   = den_neg ? -den_q : den_q;
    sn_n    = den_neg ? -sn_q : sn_q;
    tn_n    = den_neg ? -tn_q : tn_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1x_q <= DiffW'(edge_i.p1x) - DiffW'(edge_i.p0x);
      s1y_q <= DiffW'(edge_i.p1y) - DiffW'(edge_i.p0y);
      s2x_q <= DiffW'(edge_i.e1x) - DiffW'(edge_i.e0x);
      s2y_q <= DiffW'(edge_i.e1y) - DiffW'(edge_i.e0y);
      dx_q  <= DiffW'(edge_i.p0x) - DiffW'(edge_i.e0x);
      dy_q  <= DiffW'(edge_i.p0y) - DiffW'(edge_i.e0y);

      p_a_q <= ProdW'(s1x_q) * ProdW'(s2y_q);
      p_b_q <= ProdW'(s2x_q) * ProdW'(s1y_q);
      p_c_q <= ProdW'(s1x_q) * ProdW'(dy_q);
      p_d_q <= ProdW'(s1y_q) * ProdW'(dx_q);
      p_e_q <= ProdW'(s2x_q) * ProdW'(dy_q);
      p_f_q <= ProdW'(s2y_q) * ProdW'(dx_q);

      den_q <= CrossW'(p_a_q) - CrossW'(p_b_q);
      sn_q  <= CrossW'(p_c_q) - CrossW'(p_d_q);
      tn_q  <= CrossW'(p_e_q) - CrossW'(p_f_q);

      dmag_q <= den_n[MagW-1:0];
      tmag_q <= tn_n[MagW-1:0];
      ok_q   <= (den_q != '0) && !sn_n[CrossW-1] && !tn_n[CrossW-1]
                && (sn_n <= den_n) && (tn_n <= den_n);

      // First quotient bit: t is at most one, so tn >= den means exactly one.
      rem_q[0] <= (tmag_q >= dmag_q) ? (MagW+1)'(tmag_q - dmag_q)
                                     : (MagW+1)'(tmag_q);
      quo_q[0] <= FracW'(tmag_q >= dmag_q);
      dv_q[0]  <= dmag_q;
      hv_q[0]  <= ok_q;
      for (int i = 1; i < DivSteps; i++) begin
        if ({rem_q[i-1][MagW-1:0], 1'b0} >= {1'b0, dv_q[i-1]}) begin
          rem_q[i] <= {rem_q[i-1][MagW-1:0], 1'b0} - {1'b0, dv_q[i-1]};
          quo_q[i] <= {quo_q[i-1][FracW-2:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i-1][MagW-1:0], 1'b0};
          quo_q[i] <= {quo_q[i-1][FracW-2:0], 1'b0};
        end
        dv_q[i] <= dv_q[i-1];
        hv_q[i] <= hv_q[i-1];
      end
    end
  end

  assign res_o.hit  = hv_q[DivSteps-1];
  assign res_o.frac = quo_q[DivSteps-1];

endmodule

[hdl/sri_merge.sv]
// ----------------------------------------------------------------------------
// sri_merge: lane result merge
// Picks the smallest hit fraction over the four lanes.
// ----------------------------------------------------------------------------
module sri_merge import sri_pkg::*; (
  input  lane_res_t lane_i [NumLanes],
  output sri_out_t  res_o
);

  lane_res_t lo_a, lo_b, lo_c;

  function automatic lane_res_t pick(lane_res_t a, lane_res_t b);
    lane_res_t r;
    if (a.hit && (!b.hit || a.frac <= b.frac)) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  always_comb begin
    lo_a = pick(lane_i[0], lane_i[1]);
    lo_b = pick(lane_i[2], lane_i[3]);
    lo_c = pick(lo_a, lo_b);
    res_o.hit          = lo_a.hit | lo_b.hit;
    res_o.hit_fraction = res_o.hit ? lo_c.frac : '0;
  end

endmodule

[hdl/segment_rectangle_intersection.sv]
// ----------------------------------------------------------------------------
// segment_rectangle_intersection: segment versus quadrilateral test
// A lane per edge tests every edge concurrently; combinational merge logic reports any
// hit and the smallest segment parameter as an unsigned Q1.16 fraction.
// ----------------------------------------------------------------------------
//
//   channel | valid    | stall    | payload
//   --------+----------+----------+-----------------------
//   input   | valid_i  | stall_o  | in_i  (sri_in_t)
//   output  | valid_o  | stall_i  | out_o (sri_out_t)
//
// One transfer is accepted per cycle while stall_o is low. The path is four
// stages of differences, products, cross products and normalization, then
// one restoring-divider stage per quotient bit, then the output register.
// The whole pipeline freezes while a result waits under stall; stall_o
// follows stall_i only when the output register holds a result.
// Reset clears the valid bits; payload registers are not reset.
module segment_rectangle_intersection import sri_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  sri_in_t  in_i,
  output logic     valid_o,
  input  logic     stall_i,
  output sri_out_t out_o
);

  logic [LaneDepth-1:0] vld_q;
  logic                 out_vld_q;
  sri_out_t             out_q;
  logic                 adv;
  edge_in_t             edges [NumLanes];
  lane_res_t            lres  [NumLanes];
  sri_out_t             merged;

  // The pipeline moves unless a finished result sits stalled at the output.
  assign adv     = !(out_vld_q && stall_i);
  assign stall_o = !adv;

  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      edges[k].p0x = in_i.seg_start_x;
      edges[k].p0y = in_i.seg_start_y;
      edges[k].p1x = in_i.seg_end_x;
      edges[k].p1y = in_i.seg_end_y;
    end
    edges[0].e0x = in_i.corner_a_x;  edges[0].e0y = in_i.corner_a_y;
    edges[0].e1x = in_i.corner_b_x;  edges[0].e1y = in_i.corner_b_y;
    edges[1].e0x = in_i.corner_b_x;  edges[1].e0y = in_i.corner_b_y;
    edges[1].e1x = in_i.corner_c_x;  edges[1].e1y = in_i.corner_c_y;
    edges[2].e0x = in_i.corner_c_x;  edges[2].e0y = in_i.corner_c_y;
    edges[2].e1x = in_i.corner_d_x;  edges[2].e1y = in_i.corner_d_y;
    edges[3].e0x = in_i.corner_d_x;  edges[3].e0y = in_i.corner_d_y;
    edges[3].e1x = in_i.corner_a_x;  edges[3].e1y = in_i.corner_a_y;
  end

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    sri_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .edge_i (edges[k]),
      .res_o  (lres[k])
    );
  end

  sri_merge u_merge (
    .lane_i (lres),
    .res_o  (merged)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[LaneDepth-2:0], valid_i};
      out_vld_q <= vld_q[LaneDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= merged;
    end
  end

  assign valid_o = out_vld_q;
  assign out_o   = out_q;

endmodule

[hdl/sri_checker.sv]
// ----------------------------------------------------------------------------
// sri_checker: port-level checks
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module sri_checker import sri_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     stall_o,
  input logic     valid_o,
  input logic     stall_i,
  input sri_out_t out_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_o))
    else $error("stalled result changed");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_o.hit |-> out_o.hit_fraction == '0)
    else $error("miss with nonzero fraction");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.hit_fraction[FracW-1] |-> out_o.hit_fraction[FracW-2:0] == '0)
    else $error("fraction above one");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output stall");

endmodule

bind segment_rectangle_intersection sri_checker u_sri_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .stall_o (stall_o),
  .valid_o (valid_o),
  .stall_i (stall_i),
  .out_o   (out_o)
);

[tb/sv/segment_rectangle_intersection_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_rectangle_intersection_tb: self-checking testbench
// Sends segment and quadrilateral transfers through the valid/stall input,
// predicts the first hit parameter of every transfer with exact 128-bit
// arithmetic, and compares each output transfer with the oldest prediction
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module segment_rectangle_intersection_tb;
  import sri_pkg::*;

  typedef logic signed [127:0] wide_t;

  // One unit in Q16.16.
  localparam int Unit = 1 << 16;
  // Cycles without any transfer after which the run is declared hung. It
  // covers the long receiver hold plus the pipeline refill several times.
  localparam int WatchdogLimit = 3000;
  // Length of the deliberate receiver hold, in cycles.
  localparam int LongHold = 300;
  localparam int RandomItems = 1500;

  logic     clk_i;
  logic     rst_ni;
  logic     valid_i;
  logic     stall_o;
  sri_in_t  in_i;
  logic     valid_o;
  logic     stall_i;
  sri_out_t out_o;

  segment_rectangle_intersection u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .in_i   (in_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .out_o  (out_o)
  );

  // Predicted results, oldest first.
  sri_out_t hit_q[$];
  int       n_errors;
  // Set when the sender has already lowered valid after its last transfer.
  bit       tx_low;
  // While set, the sender or receiver runs without idle cycles.
  bit       tx_quiet;
  bit       rx_quiet;
  // The test asks for a long hold by bumping hold_asked; the receiver
  // notices the difference and counts the hold itself.
  int       hold_asked;
  int       hold_seen;
  int       hold_left;
  int       rx_wait;
  bit       out_fire;
  int       idle_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Tests one edge e0->e1 against the segment. On a hit, frac receives the
  // segment parameter truncated to FracBits fraction bits.
  function automatic bit edge_crossing(input longint p0x, p0y, p1x, p1y,
                                       input longint e0x, e0y, e1x, e1y,
                                       output logic [FracW-1:0] frac);
    longint s1x, s1y, s2x, s2y, dx, dy;
    wide_t  den, sn, tn, q;
    s1x = p1x - p0x;
    s1y = p1y - p0y;
    s2x = e1x - e0x;
    s2y = e1y - e0y;
    dx  = p0x - e0x;
    dy  = p0y - e0y;
    den = wide_t'(s1x) * wide_t'(s2y) - wide_t'(s2x) * wide_t'(s1y);
    sn  = wide_t'(s1x) * wide_t'(dy) - wide_t'(s1y) * wide_t'(dx);
    tn  = wide_t'(s2x) * wide_t'(dy) - wide_t'(s2y) * wide_t'(dx);
    frac = '0;
    // A parallel or collinear edge never counts, even when it overlaps.
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      sn  = -sn;
      tn  = -tn;
    end
    if (sn < 0 || tn < 0 || sn > den || tn > den) return 1'b0;
    q = (tn <<< FracBits) / den;
    frac = q[FracW-1:0];
    return 1'b1;
  endfunction

  // Expected result of one input transfer: any hit and the nearest one.
  function automatic sri_out_t nearest_hit(input sri_in_t it);
    longint cx[4], cy[4];
    logic [FracW-1:0] f;
    sri_out_t r;
    cx[0] = it.corner_a_x;  cy[0] = it.corner_a_y;
    cx[1] = it.corner_b_x;  cy[1] = it.corner_b_y;
    cx[2] = it.corner_c_x;  cy[2] = it.corner_c_y;
    cx[3] = it.corner_d_x;  cy[3] = it.corner_d_y;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      if (edge_crossing(it.seg_start_x, it.seg_start_y, it.seg_end_x, it.seg_end_y,
                        cx[k], cy[k], cx[(k + 1) % 4], cy[(k + 1) % 4], f)) begin
        if (!r.hit || f < r.hit_fraction) r.hit_fraction = f;
        r.hit = 1'b1;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking and receiver side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // Both sides change their signals only at the rising edge, so at the
  // falling edge everything that decides the next transfer is stable.
  always @(negedge clk_i) begin
    sri_out_t want;
    out_fire = valid_o && !stall_i && rst_ni;
    if (out_fire) begin
      if (hit_q.size() == 0) begin
        report_mismatch("unexpected result, hit", out_o.hit, 0);
      end else begin
        want = hit_q.pop_front();
        if (out_o.hit !== want.hit)
          report_mismatch("hit", out_o.hit, want.hit);
        if (out_o.hit_fraction !== want.hit_fraction)
          report_mismatch("hit_fraction", out_o.hit_fraction, want.hit_fraction);
      end
    end
    if (out_fire || (valid_i && !stall_o && rst_ni)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired at %0t with %0d results pending", $time, hit_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // The receiver stalls a random number of cycles before each transfer, and
  // once in the run it holds off for a long stretch so the pipeline fills.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i   <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
      rx_wait   <= 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= LongHold - 1;
      stall_i   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      stall_i   <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      stall_i <= 1'b1;
    end else if (out_fire && !rx_quiet) begin
      int n;
      n = $urandom_range(0, 9);
      rx_wait <= (n > 0) ? n - 1 : 0;
      stall_i <= (n > 0);
    end else begin
      stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one transfer, waits for acceptance, records the prediction and
  // then idles for a random gap. With no gap, valid simply stays high.
  task automatic send_item(input sri_in_t item);
    bit taken;
    int gap;
    valid_i <= 1'b1;
    in_i    <= item;
    do begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end while (!taken);
    hit_q.push_back(nearest_hit(item));
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    tx_low = (gap > 0);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    if (!tx_low) begin
      valid_i <= 1'b0;
      tx_low = 1'b1;
    end
  endtask

  task automatic wait_drained();
    while (hit_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic sri_in_t make_item(input int sx, sy, ex, ey,
                                        input int ax, ay, bx, by,
                                        input int cx, cy, dx, dy);
    sri_in_t it;
    it.seg_start_x = sx;  it.seg_start_y = sy;
    it.seg_end_x   = ex;  it.seg_end_y   = ey;
    it.corner_a_x  = ax;  it.corner_a_y  = ay;
    it.corner_b_x  = bx;  it.corner_b_y  = by;
    it.corner_c_x  = cx;  it.corner_c_y  = cy;
    it.corner_d_x  = dx;  it.corner_d_y  = dy;
    return it;
  endfunction

  // A well-formed scene: a parallelogram, possibly rotated, with a beam aimed
  // near it. Coordinates are sometimes snapped to whole units so that
  // exact corner touches and end-on-edge cases come up.
  function automatic sri_in_t random_scene();
    int span, cx, cy, ux, uy, vx, vy, sx, sy, ex, ey;
    bit snap;
    span = (1 << $urandom_range(4, 26));
    snap = ($urandom_range(0, 3) == 0);
    cx = $urandom_range(0, 2 * span) - span;
    cy = $urandom_range(0, 2 * span) - span;
    ux = $urandom_range(0, span);
    uy = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, span / 4);
    vx = -uy;
    vy = ux / ($urandom_range(1, 3));
    sx = cx + $urandom_range(0, 6 * span) - 3 * span;
    sy = cy + $urandom_range(0, 6 * span) - 3 * span;
    ex = cx + $urandom_range(0, 2 * span) - span;
    ey = cy + $urandom_range(0, 2 * span) - span;
    if (snap) begin
      cx = (cx % 64) * Unit;  cy = (cy % 64) * Unit;
      ux = (ux % 16) * Unit;  uy = 0;  vx = 0;  vy = (vy % 16) * Unit;
      sx = (sx % 128) * Unit; sy = (sy % 128) * Unit;
      ex = cx + ux;           ey = (ey % 128) * Unit;
    end
    return make_item(sx, sy, ex, ey,
                     cx + ux + vx, cy + uy + vy, cx - ux + vx, cy - uy + vy,
                     cx - ux - vx, cy - uy - vy, cx + ux - vx, cy + uy - vy);
  endfunction

  function automatic sri_in_t random_noise();
    sri_in_t it;
    for (int k = 0; k < 12; k++) it[k * 32 +: 32] = $urandom();
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked geometry around the square (0,0)-(4,4).
  task automatic test_directed();
    int u, mx, mn;
    u  = Unit;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    // Straight through the middle, first hit at t = 1/4.
    send_item(make_item(-4*u, 2*u, 12*u, 2*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Segment misses completely.
    send_item(make_item(-4*u, 9*u, 12*u, 9*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Segment ends exactly on an edge: t = 1.0.
    send_item(make_item(-4*u, 2*u, 0, 2*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Segment starts on an edge: t = 0.
    send_item(make_item(0, 2*u, -4*u, 2*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Diagonal through two corners: corner touches count.
    send_item(make_item(-u, -u, 5*u, 5*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Collinear with an edge and overlapping it: no hit from that edge.
    send_item(make_item(-u, 0, 2*u, 0, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Horizontal like the top and bottom edges, outside the square.
    send_item(make_item(-u, 5*u, 6*u, 5*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Zero-length segment sitting on an edge.
    send_item(make_item(2*u, 0, 2*u, 0, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Fully degenerate quadrilateral: all corners equal.
    send_item(make_item(-u, -u, u, u, 0, 0, 0, 0, 0, 0, 0, 0));
    // Beam starting inside, leaving through one edge.
    send_item(make_item(u, 2*u, 9*u, 2*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Fraction that is not a power of two: t = 1/3.
    send_item(make_item(-2*u, 2*u, 4*u, 2*u, 0, 0, 4*u, 0, 4*u, 4*u, 0, 4*u));
    // Rotated diamond.
    send_item(make_item(-8*u, u, 8*u, -u, 4*u, 0, 0, 4*u, -4*u, 0, 0, -4*u));
    // Extremes of the coordinate range.
    send_item(make_item(mn, mn, mx, mx, mn, mx, mx, mx, mx, mn, mn, mn));
    send_item(make_item(mn, 0, mx, 0, 0, mn, 0, mx, 1, mx, 1, mn));
    send_item(make_item(mx, mx, mn, mn, mx, mn, mn, mx, mx, mx, mn, mn));
    send_item(make_item(mn, mn, mn, mn, mx, mx, mx, mx, mx, mx, mx, mx));
    send_item(make_item(mx, mn, mn, mx, mn, mn, mx, mx, mn, mx, mx, mn));
    send_item(make_item(-1, -1, 1, 1, -1, 1, 1, 1, 1, -1, -1, -1));
    // Alternating bit patterns so every input bit toggles early.
    send_item(make_item(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
                        32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
    send_item(make_item(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                        32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
  endtask

  // Mostly well-formed scenes with random content, the rest raw noise.
  // Some stretches run with neither side idling.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        tx_quiet = ($urandom_range(0, 2) == 0);
        rx_quiet = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 9) < 8) send_item(random_scene());
      else send_item(random_noise());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back to back, so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    hold_asked++;
    tx_quiet = 1'b1;
    for (int i = 0; i < 60; i++) send_item(random_scene());
    tx_quiet = 1'b0;
  endtask

  // The sender goes quiet until every result is back, then resumes.
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_item(random_scene());
    stop_sending();
    wait_drained();
    for (int i = 0; i < 20; i++) send_item(random_scene());
  endtask

  initial begin
    n_errors    = 0;
    tx_low      = 1'b1;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    hold_asked  = 0;
    idle_cycles = 0;
    out_fire    = 1'b0;
    valid_i     = 1'b0;
    in_i        = '0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(RandomItems);
    test_drain_pause();

    stop_sending();
    wait_drained();
    repeat (LaneDepth + 8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
